/* rtl/core/rhto_pkg.sv */
// Shared types and constants for the rectangle hit-test and overlap engine.
// Used by rect_hit_test_overlap_engine; depends on nothing else.
package rhto_pkg;

  // Table size and coordinate format
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int COORD_W     = 20;
  localparam int EXT_W       = COORD_W + 1;
  localparam int KIND_W      = 3;
  localparam int OUT_IDX_W   = 6;
  localparam int PCNT_W      = 11;
  localparam int CAP_W       = 6;

  // Stream payload widths
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 24;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = EXT_W;

  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_APPEND  = 2'd1,
    FN_HIT     = 2'd2,
    FN_OVERLAP = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_INVALID      = 3'd2,
    ST_CAP_EXCEEDED = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_EXTENT = 3'd0,
    CFG_OVL_CAP    = 3'd1,
    CFG_KIND_MIN   = 3'd2,
    CFG_KIND_MAX   = 3'd3,
    CFG_TEXT_KIND  = 3'd4
  } cfg_idx_t;

  // One table entry: origin, far edges (origin plus size) and attributes
  typedef struct packed {
    logic              shown;
    logic [KIND_W-1:0] kind;
    logic [EXT_W-1:0]  ye;
    logic [EXT_W-1:0]  xe;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } entry_t;

  localparam logic [PCNT_W-1:0] COUNT_MAX = {PCNT_W{1'b1}};

endpackage

/* rtl/core/rect_hit_test_overlap_engine.sv */
// Rectangle table with append, clear, point hit test and overlap pair listing.
// Depends on rhto_pkg; holds the entry table as a one-port-read synchronous memory.
//
//  channel   dir  handshake                    payload
//  s_axis    in   tvalid/tready                tuser=func, tdata=element or query
//  m_axis    out  tvalid/tready, tlast         tuser=status, tdata=indices, count
//  cfg       in   cfg_wr_en (no back-pressure) cfg_addr, cfg_wdata
//
// Clear and append are accepted, then answered with a single item.
// A hit test reads one table entry per cycle, newest first, until a hit or the oldest entry.
// Overlap listing walks every eligible pair through the single read port of the table.
// Reset empties the table and loads the register defaults; no clearing pass.
// A stalled result holds the walk at the next pair to emit; one finished item may
// wait in the output register while the next input item is taken.
module rect_hit_test_overlap_engine (
  input  logic                               clk,
  input  logic                               rst,
  // s_axis_tdata: coord_x[19:0], coord_y[39:20], size_w[59:40], size_h[79:60],
  //               elem_kind[82:80], elem_shown[83], zero fill [87:84]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rhto_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // s_axis_tuser: func[1:0]
  input  logic [1:0]                         s_axis_tuser,
  // m_axis_tdata: first_index[5:0], second_index[11:6], pair_count[22:12], zero [23]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rhto_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // m_axis_tuser: status[2:0]
  output logic [2:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_wr_en,
  input  logic [rhto_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rhto_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rhto_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HIT  = 5'b00010,
    S_OV_A = 5'b00100,
    S_OV_B = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers
  logic [EXT_W-1:0]  max_extent;
  logic [CAP_W-1:0]  overlap_capacity;
  logic [KIND_W-1:0] kind_min;
  logic [KIND_W-1:0] kind_max;
  logic [KIND_W-1:0] text_kind;

  // Table state
  entry_t            mem [MAX_ENTRIES];
  entry_t            rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  entry_t            wr_entry;
  logic [CNT_W-1:0]  entry_count;
  logic              frame_bad;

  // Walk registers
  logic [IDX_W-1:0]   cur;
  logic [IDX_W-1:0]   ai;
  entry_t             a_ent;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;

  // Pending single answer
  status_t            resp_status;
  logic [IDX_W-1:0]   resp_first;
  logic [PCNT_W-1:0]  resp_count;

  // Output register
  status_t             out_status;
  logic [OUT_IDX_W-1:0] out_first;
  logic [OUT_IDX_W-1:0] out_second;
  logic [PCNT_W-1:0]   out_count;

  // Input fields
  func_t              in_func;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [COORD_W-1:0] in_w;
  logic [COORD_W-1:0] in_h;
  logic [KIND_W-1:0]  in_kind;
  logic               in_shown;
  logic [EXT_W-1:0]   in_xe;
  logic [EXT_W-1:0]   in_ye;

  logic in_acc;
  logic slot_free;
  logic tbl_full;
  logic elem_bad;
  logic rd_elig;
  logic pt_hit;
  logic pair_hit;
  logic ov_emit;
  logic ov_stall;
  logic resp_load;
  logic pair_load;
  logic [CNT_W-1:0] ai_inc;
  logic [CNT_W-1:0] cur_inc;
  logic i_more;
  logic j_more;

  // Unpack the input item
  assign in_func  = func_t'(s_axis_tuser);
  assign in_x     = s_axis_tdata[19:0];
  assign in_y     = s_axis_tdata[39:20];
  assign in_w     = s_axis_tdata[59:40];
  assign in_h     = s_axis_tdata[79:60];
  assign in_kind  = s_axis_tdata[82:80];
  assign in_shown = s_axis_tdata[83];
  assign in_xe    = {1'b0, in_x} + {1'b0, in_w};
  assign in_ye    = {1'b0, in_y} + {1'b0, in_h};

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;

  // Append checks, judged with the registers as they stand now
  assign tbl_full = (entry_count >= CNT_W'(MAX_ENTRIES));
  assign elem_bad = (in_w == '0) || (in_h == '0) || (in_xe > max_extent) ||
                    (in_ye > max_extent) || (in_kind < kind_min) || (in_kind > kind_max);

  assign wr_en    = in_acc && (in_func == FN_APPEND) && !tbl_full;
  assign wr_entry = '{shown: in_shown, kind: in_kind, ye: in_ye, xe: in_xe,
                      y: in_y, x: in_x};

  // Entry tests on the word just read
  assign rd_elig  = rd_q.shown && (rd_q.kind != text_kind);
  assign pt_hit   = rd_q.shown && (qx >= rd_q.x) && ({1'b0, qx} < rd_q.xe) &&
                    (qy >= rd_q.y) && ({1'b0, qy} < rd_q.ye);
  assign pair_hit = rd_elig && ({1'b0, a_ent.x} < rd_q.xe) && ({1'b0, rd_q.x} < a_ent.xe) &&
                    ({1'b0, a_ent.y} < rd_q.ye) && ({1'b0, rd_q.y} < a_ent.ye);
  assign ov_emit  = pair_hit && (resp_count < PCNT_W'(overlap_capacity));
  assign ov_stall = ov_emit && !slot_free;

  assign ai_inc  = {1'b0, ai} + CNT_W'(1);
  assign cur_inc = {1'b0, cur} + CNT_W'(1);
  assign i_more  = ai_inc < entry_count;
  assign j_more  = cur_inc < entry_count;

  assign resp_load = (state == S_RESP) && slot_free;
  assign pair_load = (state == S_OV_B) && ov_emit && slot_free;

  // Select the table word to read next
  always_comb begin
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        if (in_func == FN_HIT) begin
          rd_addr = IDX_W'(entry_count - CNT_W'(1));
        end
      end
      S_HIT:  rd_addr = cur - IDX_W'(1);
      S_OV_A: rd_addr = IDX_W'(ai_inc);
      S_OV_B: begin
        if (ov_stall) begin
          rd_addr = cur;
        end else if (j_more) begin
          rd_addr = IDX_W'(cur_inc);
        end else begin
          rd_addr = IDX_W'(ai_inc);
        end
      end
      S_RESP: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  // Table memory: writes only from idle; the read word is registered unconditionally
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(entry_count)] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_extent       <= EXT_W'(1048575);
      overlap_capacity <= CAP_W'(63);
      kind_min         <= KIND_W'(0);
      kind_max         <= KIND_W'(3);
      text_kind        <= KIND_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MAX_EXTENT: max_extent       <= cfg_wdata;
        CFG_OVL_CAP:    overlap_capacity <= cfg_wdata[CAP_W-1:0];
        CFG_KIND_MIN:   kind_min         <= cfg_wdata[KIND_W-1:0];
        CFG_KIND_MAX:   kind_max         <= cfg_wdata[KIND_W-1:0];
        CFG_TEXT_KIND:  text_kind        <= cfg_wdata[KIND_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: decode the item, walk the table, stage the answer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      frame_bad   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            qx          <= in_x;
            qy          <= in_y;
            resp_first  <= '0;
            resp_count  <= '0;
            unique case (in_func)
              FN_CLEAR: begin
                entry_count <= '0;
                frame_bad   <= 1'b0;
                resp_status <= ST_OK;
                state       <= S_RESP;
              end
              FN_APPEND: begin
                state <= S_RESP;
                if (tbl_full) begin
                  resp_status <= ST_FULL;
                end else begin
                  entry_count <= entry_count + CNT_W'(1);
                  if (elem_bad) begin
                    frame_bad   <= 1'b1;
                    resp_status <= ST_INVALID;
                  end else begin
                    resp_status <= ST_OK;
                  end
                end
              end
              FN_HIT: begin
                if (frame_bad) begin
                  resp_status <= ST_INVALID;
                  state       <= S_RESP;
                end else if (entry_count == '0) begin
                  resp_status <= ST_NOT_FOUND;
                  state       <= S_RESP;
                end else begin
                  resp_status <= ST_OK;
                  cur         <= IDX_W'(entry_count - CNT_W'(1));
                  state       <= S_HIT;
                end
              end
              FN_OVERLAP: begin
                if (frame_bad) begin
                  resp_status <= ST_INVALID;
                  state       <= S_RESP;
                end else if (entry_count != '0) begin
                  resp_status <= ST_OK;
                  ai          <= '0;
                  state       <= S_OV_A;
                end else begin
                  resp_status <= ST_OK;
                  state       <= S_RESP;
                end
              end
              default: ;
            endcase
          end
        end
        S_HIT: begin
          // Newest entry first; stop at the first visible box holding the point
          if (pt_hit) begin
            resp_first <= cur;
            state      <= S_RESP;
          end else if (cur == '0) begin
            resp_status <= ST_NOT_FOUND;
            state       <= S_RESP;
          end else begin
            cur <= cur - IDX_W'(1);
          end
        end
        S_OV_A: begin
          // Hold the outer entry if it takes part, else move on
          if (rd_elig && i_more) begin
            a_ent <= rd_q;
            cur   <= IDX_W'(ai_inc);
            state <= S_OV_B;
          end else if (i_more) begin
            ai <= IDX_W'(ai_inc);
          end else begin
            resp_status <= (resp_count > PCNT_W'(overlap_capacity)) ? ST_CAP_EXCEEDED : ST_OK;
            state       <= S_RESP;
          end
        end
        S_OV_B: begin
          if (!ov_stall) begin
            if (pair_hit && (resp_count != COUNT_MAX)) begin
              resp_count <= resp_count + PCNT_W'(1);
            end
            if (j_more) begin
              cur <= IDX_W'(cur_inc);
            end else begin
              ai    <= IDX_W'(ai_inc);
              state <= S_OV_A;
            end
          end
        end
        S_RESP: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load a new item, else drop a taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (resp_load || pair_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (resp_load) begin
      out_status   <= resp_status;
      out_first    <= OUT_IDX_W'(resp_first);
      out_second   <= '0;
      out_count    <= resp_count;
      m_axis_tlast <= 1'b1;
    end else if (pair_load) begin
      out_status   <= ST_OK;
      out_first    <= OUT_IDX_W'(ai);
      out_second   <= OUT_IDX_W'(cur);
      out_count    <= '0;
      m_axis_tlast <= 1'b0;
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {1'b0, out_count, out_second, out_first};

`ifndef NO_ASSERTIONS
  // Pair items are always ok and ordered lower index first
  a_pair_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ST_OK)
    else $error("pair item with non-ok status");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[5:0] < m_axis_tdata[11:6])
    else $error("pair item indices out of order");

  // Fill level never passes the table depth
  a_fill: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  // Inner walk stays above the outer entry and inside the table
  a_inner: assert property (@(posedge clk) disable iff (rst)
    state == S_OV_B |-> (ai < cur) && ({1'b0, cur} < entry_count))
    else $error("overlap walk indices out of range");

  // A held pair item keeps the walk parked
  a_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_OV_B && ov_stall |=> state == S_OV_B && $stable(cur) && $stable(ai))
    else $error("overlap walk moved while output stalled");
`endif

endmodule
